### hdl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)

`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)

`endif

`endif

### hdl/dlx_pkg.sv
`default_nettype none

package dlx_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 5;
  localparam int LEN_W = 8;
  localparam int STATE_W = 5;
  localparam int PREFIX_CHARS = 5;
  localparam int PREFIX_W = PREFIX_CHARS * CHAR_W;

  localparam int LENGTH_LIMIT_DEF = 255;
  localparam int RESULT_DEPTH_DEF = 4;

  localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd0;
  localparam logic [KIND_W-1:0] KIND_EOF      = 5'd1;
  localparam logic [KIND_W-1:0] KIND_INT      = 5'd2;
  localparam logic [KIND_W-1:0] KIND_REAL     = 5'd3;
  localparam logic [KIND_W-1:0] KIND_ADDOP    = 5'd4;
  localparam logic [KIND_W-1:0] KIND_MULOP    = 5'd5;
  localparam logic [KIND_W-1:0] KIND_ID       = 5'd6;
  localparam logic [KIND_W-1:0] KIND_RELOP    = 5'd7;
  localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd8;
  localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd9;
  localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd10;
  localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_LBRACK   = 5'd12;
  localparam logic [KIND_W-1:0] KIND_RBRACK   = 5'd13;
  localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_AND      = 5'd15;
  localparam logic [KIND_W-1:0] KIND_OR       = 5'd16;
  localparam logic [KIND_W-1:0] KIND_KEYWORD0 = 5'd17;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic              last;
  } result_t;

  // Results of one character: count is 0, 1 or 2, first slot filled first.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

endpackage

`default_nettype wire

### hdl/dlx_step.sv
`default_nettype none

module dlx_step #(
  parameter int LENGTH_LIMIT = dlx_pkg::LENGTH_LIMIT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire logic [dlx_pkg::CHAR_W-1:0]  char_code,
  input  wire logic                        end_of_input,
  output dlx_pkg::step_out_t               step_out
);

  localparam int CNT_W = $clog2(LENGTH_LIMIT + 1);
  localparam int WIDE_W = CNT_W + dlx_pkg::LEN_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LENGTH_LIMIT);
  localparam logic [dlx_pkg::LEN_W-1:0] LEN_MAX = '1;
  localparam int KW_NUM = 9;

  localparam logic [4:0] S_START  = 5'd0;
  localparam logic [4:0] S_ID     = 5'd1;
  localparam logic [4:0] S_INT    = 5'd2;
  localparam logic [4:0] S_DOT    = 5'd3;
  localparam logic [4:0] S_REAL   = 5'd4;
  localparam logic [4:0] S_ADD    = 5'd5;
  localparam logic [4:0] S_MUL    = 5'd6;
  localparam logic [4:0] S_REL    = 5'd7;
  localparam logic [4:0] S_REL_EQ = 5'd8;
  localparam logic [4:0] S_ASSIGN = 5'd9;
  localparam logic [4:0] S_LPAREN = 5'd10;
  localparam logic [4:0] S_RPAREN = 5'd11;
  localparam logic [4:0] S_AMP    = 5'd12;
  localparam logic [4:0] S_AND    = 5'd13;
  localparam logic [4:0] S_BAR    = 5'd14;
  localparam logic [4:0] S_OR     = 5'd15;
  localparam logic [4:0] S_SEMI   = 5'd16;
  localparam logic [4:0] S_LBRACK = 5'd17;
  localparam logic [4:0] S_RBRACK = 5'd18;
  localparam logic [4:0] S_COMMA  = 5'd19;
  localparam logic [4:0] S_NONE   = 5'd31;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // Keywords, first character in the low byte, zero padded.
  localparam logic [dlx_pkg::PREFIX_W-1:0] KW_TEXT [KW_NUM] = '{
    40'h0000746E69,  // int
    40'h74616F6C66,  // float
    40'h656C696877,  // while
    40'h0000006669,  // if
    40'h006E656874,  // then
    40'h0065736C65,  // else
    40'h0064696F76,  // void
    40'h6E69676562,  // begin
    40'h0000646E65   // end
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd5, 3'd5, 3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd3
  };

  logic [4:0]                     dfa_state, dfa_state_next;
  logic                           in_comment, in_comment_next;
  logic [CNT_W-1:0]               token_count, token_count_next;
  logic [dlx_pkg::PREFIX_W-1:0]   keyword_prefix, keyword_prefix_next;

  logic [4:0]                     ns_cur, ns_start;
  logic                           fin_valid;
  dlx_pkg::result_t               fin_res, err_res, eof_res;
  logic [dlx_pkg::KIND_W-1:0]     id_kind;
  logic [WIDE_W-1:0]              count_wide;
  logic [dlx_pkg::LEN_W-1:0]      len_sat;
  logic                           space;
  logic [1:0]                     n;
  dlx_pkg::result_t               r0, r1;

  function automatic logic [4:0] next_state(input logic [4:0] s, input logic [7:0] c);
    logic letter;
    logic digit;
    logic [4:0] ns;
    letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    digit = (c >= CH_0 && c <= CH_9);
    ns = S_NONE;
    case (s)
      S_START: begin
        if (letter) begin
          ns = S_ID;
        end else if (digit) begin
          ns = S_INT;
        end else begin
          case (c)
            CH_PLUS, CH_MINUS: ns = S_ADD;
            CH_STAR, CH_SLASH: ns = S_MUL;
            CH_LT, CH_GT:      ns = S_REL;
            CH_EQ:             ns = S_ASSIGN;
            CH_LPAREN:         ns = S_LPAREN;
            CH_RPAREN:         ns = S_RPAREN;
            CH_AMP:            ns = S_AMP;
            CH_BAR:            ns = S_BAR;
            CH_SEMI:           ns = S_SEMI;
            CH_LBRACK:         ns = S_LBRACK;
            CH_RBRACK:         ns = S_RBRACK;
            CH_COMMA:          ns = S_COMMA;
            default:           ns = S_NONE;
          endcase
        end
      end
      S_ID:     ns = (letter || digit) ? S_ID : S_NONE;
      S_INT:    ns = digit ? S_INT : ((c == CH_DOT) ? S_DOT : S_NONE);
      S_DOT:    ns = digit ? S_REAL : S_NONE;
      S_REAL:   ns = digit ? S_REAL : S_NONE;
      S_REL:    ns = (c == CH_EQ) ? S_REL_EQ : S_NONE;
      S_ASSIGN: ns = (c == CH_EQ) ? S_REL_EQ : S_NONE;
      S_AMP:    ns = (c == CH_AMP) ? S_AND : S_NONE;
      S_BAR:    ns = (c == CH_BAR) ? S_OR : S_NONE;
      default:  ns = S_NONE;
    endcase
    return ns;
  endfunction

  function automatic logic [dlx_pkg::KIND_W-1:0] state_kind(input logic [4:0] s,
                                                          input logic [dlx_pkg::KIND_W-1:0] idk);
    logic [dlx_pkg::KIND_W-1:0] k;
    case (s)
      S_ID:             k = idk;
      S_INT:            k = dlx_pkg::KIND_INT;
      S_REAL:           k = dlx_pkg::KIND_REAL;
      S_ADD:            k = dlx_pkg::KIND_ADDOP;
      S_MUL:            k = dlx_pkg::KIND_MULOP;
      S_REL, S_REL_EQ:  k = dlx_pkg::KIND_RELOP;
      S_ASSIGN:         k = dlx_pkg::KIND_ASSIGN;
      S_LPAREN:         k = dlx_pkg::KIND_LPAREN;
      S_RPAREN:         k = dlx_pkg::KIND_RPAREN;
      S_SEMI:           k = dlx_pkg::KIND_SEMI;
      S_LBRACK:         k = dlx_pkg::KIND_LBRACK;
      S_RBRACK:         k = dlx_pkg::KIND_RBRACK;
      S_COMMA:          k = dlx_pkg::KIND_COMMA;
      S_AND:            k = dlx_pkg::KIND_AND;
      S_OR:             k = dlx_pkg::KIND_OR;
      default:          k = dlx_pkg::KIND_ERROR;
    endcase
    return k;
  endfunction

  // Keyword lookup: length must match, and bytes past the length are zero.
  always_comb begin
    id_kind = dlx_pkg::KIND_ID;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (token_count == CNT_W'(KW_LEN[k]) && keyword_prefix == KW_TEXT[k]) begin
        id_kind = dlx_pkg::KIND_KEYWORD0 + dlx_pkg::KIND_W'(k);
      end
    end
  end

  assign count_wide = WIDE_W'(token_count);
  assign len_sat = (count_wide > WIDE_W'(LEN_MAX)) ? LEN_MAX
                                                    : count_wide[dlx_pkg::LEN_W-1:0];

  assign ns_cur = next_state(dfa_state, char_code);
  assign ns_start = next_state(S_START, char_code);
  assign space = (char_code == CH_SPACE) || (char_code >= CH_TAB && char_code <= CH_CR);
  assign fin_valid = (dfa_state != S_START);

  always_comb begin
    fin_res = '{kind: state_kind(dfa_state, id_kind), length: len_sat, last: 1'b0};
    err_res = '{kind: dlx_pkg::KIND_ERROR, length: dlx_pkg::LEN_W'(1), last: 1'b0};
    eof_res = '{kind: dlx_pkg::KIND_EOF, length: '0, last: 1'b0};
  end

  always_comb begin
    dfa_state_next = dfa_state;
    in_comment_next = in_comment;
    token_count_next = token_count;
    keyword_prefix_next = keyword_prefix;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    if (end_of_input) begin
      dfa_state_next = S_START;
      in_comment_next = 1'b0;
      token_count_next = '0;
      keyword_prefix_next = '0;
      if (fin_valid) begin
        r0 = fin_res;
        r1 = eof_res;
        n = 2'd2;
      end else begin
        r0 = eof_res;
        n = 2'd1;
      end
    end else if (in_comment) begin
      if (char_code == CH_LF) begin
        in_comment_next = 1'b0;
      end
    end else if (char_code == CH_HASH) begin
      // close any pending token, then drop the rest of the line
      in_comment_next = 1'b1;
      dfa_state_next = S_START;
      token_count_next = '0;
      keyword_prefix_next = '0;
      if (fin_valid) begin
        r0 = fin_res;
        n = 2'd1;
      end
    end else if (ns_cur != S_NONE) begin
      dfa_state_next = ns_cur;
      for (int i = 0; i < dlx_pkg::PREFIX_CHARS; i++) begin
        if (token_count == CNT_W'(i)) begin
          keyword_prefix_next[i*dlx_pkg::CHAR_W +: dlx_pkg::CHAR_W] = char_code;
        end
      end
      if (token_count < CNT_LIMIT) begin
        token_count_next = token_count + CNT_W'(1);
      end
    end else begin
      // token ends here; rerun the character from the start state
      dfa_state_next = S_START;
      token_count_next = '0;
      keyword_prefix_next = '0;
      if (fin_valid) begin
        r0 = fin_res;
        n = 2'd1;
      end
      if (!space) begin
        if (ns_start != S_NONE) begin
          dfa_state_next = ns_start;
          token_count_next = CNT_W'(1);
          keyword_prefix_next = dlx_pkg::PREFIX_W'(char_code);
        end else if (fin_valid) begin
          r1 = err_res;
          n = 2'd2;
        end else begin
          r0 = err_res;
          n = 2'd1;
        end
      end
    end
    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end
  end

  assign step_out = '{count: n, first: r0, second: r1};

  always_ff @(posedge clk) begin
    if (rst) begin
      dfa_state <= S_START;
      in_comment <= 1'b0;
      token_count <= '0;
      keyword_prefix <= '0;
    end else if (advance) begin
      dfa_state <= dfa_state_next;
      in_comment <= in_comment_next;
      token_count <= token_count_next;
      keyword_prefix <= keyword_prefix_next;
    end
  end

endmodule

`default_nettype wire

### hdl/dlx_fifo.sv
`default_nettype none

// Result queue, up to two writes and one read per cycle. DEPTH is a power of two.
module dlx_fifo #(
  parameter int DEPTH = dlx_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_en,
  input  wire dlx_pkg::step_out_t push,
  input  wire logic               pop,
  output dlx_pkg::result_t        head,
  output logic                    not_empty,
  output logic                    room_two
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dlx_pkg::result_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       push_n;

  assign push_n = push_en ? push.count : 2'd0;
  assign count_next = count + CNT_W'(push_n) - CNT_W'(pop);

  assign head = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign room_two = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### hdl/dfa_lexer_token_classifier_unit.sv
// An accepted character word passes the input register and the result queue
// before its first result word. Throughput: one character per cycle while the
// queue has room for two results; the input register feeds the DFA step
// logic, which writes 0, 1 or 2 result words into a 4-entry result queue.
// Reset (rst, synchronous): DFA at start state, comment flag and token cleared,
// input register and result queue empty.
`default_nettype none

`include "assert_macros.svh"

module dfa_lexer_token_classifier_unit #(
  parameter int LENGTH_LIMIT = dlx_pkg::LENGTH_LIMIT_DEF,
  parameter int RESULT_DEPTH = dlx_pkg::RESULT_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_input
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [4:0] token_kind, [12:5] token_length
  output logic             m_axis_tlast    // last_result
);

  logic                        in_valid;
  logic [dlx_pkg::CHAR_W-1:0]  in_char;
  logic                        in_eoi;
  logic                        advance;
  logic                        room_two;
  logic                        not_empty;
  logic                        pop;
  dlx_pkg::step_out_t          step_out;
  dlx_pkg::result_t            head;

  assign advance = in_valid && room_two;
  assign s_axis_tready = !in_valid || advance;
  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // hold the word until the queue has room for two results
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_eoi <= s_axis_tlast;
    end
  end

  dlx_step #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .char_code    (in_char),
    .end_of_input (in_eoi),
    .step_out     (step_out)
  );

  dlx_fifo #(
    .DEPTH(RESULT_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_en   (advance),
    .push      (step_out),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room_two  (room_two)
  );

  assign m_axis_tvalid = not_empty;
  assign m_axis_tdata = {3'b000, head.length, head.kind};
  assign m_axis_tlast = head.last;

  `ASSERT_IMPLY(a_eof_is_last, clk, rst, m_axis_tvalid && (m_axis_tdata[4:0] == dlx_pkg::KIND_EOF), m_axis_tlast, "EOF word without last flag")
  `ASSERT_IMPLY(a_pair_last, clk, rst, advance && (step_out.count == 2'd2), !step_out.first.last && step_out.second.last, "two results with wrong last flags")
  `ASSERT_IMPLY(a_eoi_gives_eof, clk, rst, advance && in_eoi, (step_out.count == 2'd1 && step_out.first.kind == dlx_pkg::KIND_EOF) || (step_out.count == 2'd2 && step_out.second.kind == dlx_pkg::KIND_EOF), "end of input without EOF result")

endmodule

`default_nettype wire
